[rtl/pcst_pkg.sv]
package pcst_pkg;

  // Command codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_PAUSE  = 3'd1,
    KIND_RESUME = 3'd2,
    KIND_ADD    = 3'd3,
    KIND_END    = 3'd4,
    KIND_CANCEL = 3'd5,
    KIND_SNAP   = 3'd6,
    KIND_BAD    = 3'd7
  } kind_e;

  // Session status codes.
  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_PAUSED   = 2'd2,
    ST_UNUSED   = 2'd3
  } sess_e;

  // Configuration register indexes.
  localparam logic [7:0] REG_MIN_MINUTES = 8'd0;
  localparam logic [7:0] REG_MAX_MINUTES = 8'd1;

  localparam logic [15:0] MIN_MINUTES_RST = 16'd1;
  localparam logic [15:0] MAX_MINUTES_RST = 16'd120;

  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned PCT_SCALE    = 100;
  localparam int unsigned TIME_W       = 63;
  localparam int unsigned TOTAL_W      = 22;
  localparam int unsigned PROD_W       = 29;
  localparam int unsigned QUOT_W       = 7;

  // Controller phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_EXEC,
    PH_POST,
    PH_MUL,
    PH_DIV,
    PH_LOAD
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;
    logic calc_pre;
    logic exec;
    logic calc_post;
    logic mul;
    logic div_step;
    logic out_load;
  } pcst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic out_free;
  } pcst_sts_t;

endpackage

[rtl/pausable_countdown_session_timer.sv]
// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid/tready           tdata: kind, minutes, now_time
// m_axis    out        tvalid/tready           tdata: accepted .. done_time
// cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each command runs through five sequencer steps plus seven quotient steps of the
// percent divider between acceptance and a loaded result.
// A finished result waits in the output register while the next command runs;
// only the final load stalls when that register is still full.
// Reset sets min_minutes to 1, max_minutes to 120 and clears the session.
module pausable_countdown_session_timer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // kind[2:0], minutes[18:3], now_time[81:19]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accepted[0], session_status[2:1], length_minutes[18:3],
  // remaining_secs[50:19], progress_pct[57:51], done_pending[58], done_time[121:59]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import pcst_pkg::*;

  pcst_cmd_t cmd;
  pcst_sts_t sts;

  logic        acc;
  logic [1:0]  stat;
  logic [15:0] len;
  logic [31:0] rem;
  logic [6:0]  pct;
  logic        done;
  logic [62:0] dtime;

  assign cfg_ready_o = 1'b1;

  pcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (s_axis_tdata[2:0]),
    .minutes_i       (s_axis_tdata[18:3]),
    .now_time_i      (s_axis_tdata[81:19]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_accepted_o  (acc),
    .out_status_o    (stat),
    .out_length_o    (len),
    .out_remaining_o (rem),
    .out_pct_o       (pct),
    .out_done_o      (done),
    .out_done_time_o (dtime)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {6'b0, dtime, done, pct, rem, len, stat, acc};

endmodule

[rtl/pcst_ctrl.sv]
module pcst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcst_pkg::pcst_sts_t sts_i,
  output pcst_pkg::pcst_cmd_t cmd_o
);
  import pcst_pkg::*;

  phase_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      PH_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = PH_PRE;
        end
      end
      PH_PRE: begin
        cmd_o.calc_pre = 1'b1;
        state_d        = PH_EXEC;
      end
      PH_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = PH_POST;
      end
      PH_POST: begin
        cmd_o.calc_post = 1'b1;
        state_d         = PH_MUL;
      end
      PH_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = PH_DIV;
      end
      PH_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = PH_LOAD;
        end
      end
      PH_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = PH_IDLE;
        end
      end
      default: state_d = PH_IDLE;
    endcase
  end

  // A new command is only taken between transactions of the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_in |=> state_q == PH_PRE)
    else $error("controller did not start after a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

endmodule

[rtl/pcst_dp.sv]
module pcst_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcst_pkg::pcst_cmd_t cmd_i,
  output pcst_pkg::pcst_sts_t sts_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [2:0]          kind_i,
  input  logic [15:0]         minutes_i,
  input  logic [62:0]         now_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_accepted_o,
  output logic [1:0]          out_status_o,
  output logic [15:0]         out_length_o,
  output logic [31:0]         out_remaining_o,
  output logic [6:0]          out_pct_o,
  output logic                out_done_o,
  output logic [62:0]         out_done_time_o
);
  import pcst_pkg::*;

  // Configuration registers.
  logic [15:0] min_q, max_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_MINUTES_RST;
      max_q <= MAX_MINUTES_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MIN_MINUTES) min_q <= cfg_data_i;
      if (cfg_index_i == REG_MAX_MINUTES) max_q <= cfg_data_i;
    end
  end

  // Latched command.
  logic [2:0]        kind_q;
  logic [15:0]       mins_q;
  logic [TIME_W-1:0] now_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      kind_q <= kind_i;
      mins_q <= minutes_i;
      now_q  <= now_time_i;
    end
  end

  // Session state.
  sess_e             status_q, status_d;
  logic [15:0]       len_q, len_d;
  logic [TIME_W-1:0] dl_q, dl_d;
  logic [31:0]       frz_q, frz_d;
  logic              done_q, done_d;
  logic [TIME_W-1:0] dtime_q, dtime_d;
  logic              ok_q, ok_d;

  // Seconds left for the current state at the latched time, saturated.
  logic [63:0] diff;
  logic [31:0] left_now;
  always_comb begin
    diff = {1'b0, dl_q} - {1'b0, now_q};
    if (status_q == ST_PAUSED) begin
      left_now = frz_q;
    end else if (status_q != ST_RUNNING || diff[63] || diff == '0) begin
      left_now = '0;
    end else if (diff[62:32] != '0) begin
      left_now = '1;
    end else begin
      left_now = diff[31:0];
    end
  end

  logic [31:0] left_pre_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_pre) left_pre_q <= left_now;
  end

  // Command execution.
  logic [TOTAL_W-1:0] secs, cap;
  logic [63:0]        sum_start, sum_res, sum_add;
  logic [16:0]        len_sum;
  logic               good;
  always_comb begin
    secs      = TOTAL_W'(mins_q) * TOTAL_W'(SECS_PER_MIN);
    cap       = TOTAL_W'(max_q) * TOTAL_W'(SECS_PER_MIN);
    sum_start = {1'b0, now_q} + 64'(secs);
    sum_res   = {1'b0, now_q} + 64'(frz_q);
    sum_add   = {1'b0, dl_q} + 64'(secs);
    len_sum   = {1'b0, len_q} + {1'b0, mins_q};
    good      = (left_pre_q < 32'(cap)) && (32'(secs) <= 32'(cap) - left_pre_q)
                && (len_sum <= {1'b0, max_q})
                && !(status_q == ST_RUNNING && sum_add[63]);

    status_d = status_q;
    len_d    = len_q;
    dl_d     = dl_q;
    frz_d    = frz_q;
    done_d   = done_q;
    dtime_d  = dtime_q;
    ok_d     = 1'b0;

    if (kind_q == KIND_CANCEL) begin
      if (status_q != ST_INACTIVE) begin
        status_d = ST_INACTIVE;
        len_d    = '0;
        dl_d     = '0;
        frz_d    = '0;
        done_d   = 1'b0;
        dtime_d  = '0;
        ok_d     = 1'b1;
      end
    end else if (now_q != '0) begin
      unique case (kind_q)
        KIND_START: begin
          if (mins_q >= min_q && mins_q <= max_q && !sum_start[63]) begin
            status_d = ST_RUNNING;
            len_d    = mins_q;
            dl_d     = sum_start[TIME_W-1:0];
            frz_d    = '0;
            done_d   = 1'b0;
            dtime_d  = '0;
            ok_d     = 1'b1;
          end
        end
        KIND_PAUSE: begin
          if (status_q == ST_RUNNING) begin
            if (left_pre_q == '0) begin
              status_d = ST_INACTIVE;
              dl_d     = '0;
              frz_d    = '0;
              done_d   = 1'b1;
              dtime_d  = now_q;
            end else begin
              status_d = ST_PAUSED;
              frz_d    = left_pre_q;
              dl_d     = '0;
            end
            ok_d = 1'b1;
          end
        end
        KIND_RESUME: begin
          if (status_q == ST_PAUSED && frz_q != '0 && !sum_res[63]) begin
            status_d = ST_RUNNING;
            dl_d     = sum_res[TIME_W-1:0];
            frz_d    = '0;
            ok_d     = 1'b1;
          end
        end
        KIND_ADD: begin
          if (status_q != ST_INACTIVE && mins_q != '0 && good) begin
            len_d = len_sum[15:0];
            if (status_q == ST_PAUSED) begin
              frz_d = left_pre_q + 32'(secs);
            end else begin
              dl_d = sum_add[TIME_W-1:0];
            end
            ok_d = 1'b1;
          end
        end
        KIND_END: begin
          if (status_q != ST_INACTIVE) begin
            status_d = ST_INACTIVE;
            dl_d     = '0;
            frz_d    = '0;
            done_d   = 1'b1;
            dtime_d  = now_q;
            ok_d     = 1'b1;
          end
        end
        KIND_SNAP: begin
          if (status_q == ST_RUNNING && left_pre_q == '0) begin
            status_d = ST_INACTIVE;
            dl_d     = '0;
            frz_d    = '0;
            done_d   = 1'b1;
            dtime_d  = now_q;
          end
          ok_d = 1'b1;
        end
        default: ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_INACTIVE;
      len_q    <= '0;
      dl_q     <= '0;
      frz_q    <= '0;
      done_q   <= 1'b0;
      dtime_q  <= '0;
    end else if (cmd_i.exec) begin
      status_q <= status_d;
      len_q    <= len_d;
      dl_q     <= dl_d;
      frz_q    <= frz_d;
      done_q   <= done_d;
      dtime_q  <= dtime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) ok_q <= ok_d;
  end

  // View after the command: remaining time and the session total.
  logic [31:0]        left_q;
  logic [TOTAL_W-1:0] total_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_post) begin
      left_q  <= left_now;
      total_q <= TOTAL_W'(len_q) * TOTAL_W'(SECS_PER_MIN);
    end
  end

  // Elapsed share scaled by one hundred, then divided one quotient bit a cycle.
  logic [TOTAL_W-1:0] elapsed;
  logic [PROD_W-1:0]  rem_q, cmp;
  logic [QUOT_W-1:0]  quo_q;
  logic [2:0]         cnt_q;
  always_comb begin
    elapsed = (left_q >= 32'(total_q)) ? '0 : total_q - left_q[TOTAL_W-1:0];
    cmp     = PROD_W'(total_q) << cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q <= PROD_W'(elapsed) * PROD_W'(PCT_SCALE);
      quo_q <= '0;
      cnt_q <= 3'(QUOT_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_q >= cmp) begin
        rem_q <= rem_q - cmp;
        quo_q <= quo_q | (QUOT_W'(1) << cnt_q);
      end
      cnt_q <= cnt_q - 3'd1;
    end
  end

  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  logic [6:0] pct;
  always_comb begin
    if (left_q == '0) begin
      pct = 7'(PCT_SCALE);
    end else if (total_q == '0) begin
      pct = '0;
    end else begin
      pct = quo_q;
    end
  end

  // Output register; the next command may run while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_accepted_o  <= ok_q;
      out_status_o    <= status_q;
      out_length_o    <= len_q;
      out_remaining_o <= left_q;
      out_pct_o       <= pct;
      out_done_o      <= done_q;
      out_done_time_o <= dtime_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_INACTIVE |-> dl_q == '0 && frz_q == '0)
    else $error("inactive session keeps a deadline or a count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_RUNNING |-> frz_q == '0)
    else $error("running session keeps a frozen count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_PAUSED |-> dl_q == '0 && frz_q != '0)
    else $error("paused session state inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_pct_o <= 7'(PCT_SCALE))
    else $error("progress above one hundred percent");

endmodule

[verif/pausable_countdown_session_timer_test.sv]
module pausable_countdown_session_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcst_pkg::*;

  localparam logic [62:0] TIME_TOP    = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam int          CYCLE_LIMIT = 2000000;

  // One session report as it leaves the block.
  typedef struct packed {
    logic        accepted;
    sess_e       status;
    logic [15:0] length_min;
    logic [31:0] remaining;
    logic [6:0]  pct;
    logic        done;
    logic [62:0] done_at;
  } report_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;

  pausable_countdown_session_timer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the timer registers and session state.
  logic [15:0] shd_min;
  logic [15:0] shd_max;
  sess_e       shd_status;
  logic [15:0] shd_length;
  logic [63:0] shd_deadline;
  logic [31:0] shd_frozen;
  logic        shd_done;
  logic [62:0] shd_done_at;

  report_t     pending_reports[$];
  int          error_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_cycles;
  logic [62:0] clock_secs;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run time guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random back-pressure plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [31:0] secs_to_go(logic [62:0] now);
    logic [63:0] diff;
    if (shd_status == ST_PAUSED) return shd_frozen;
    if (shd_status != ST_RUNNING || {1'b0, now} >= shd_deadline) return 32'd0;
    diff = shd_deadline - {1'b0, now};
    return (diff > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
  endfunction

  function automatic logic [6:0] pct_elapsed(logic [31:0] left);
    logic [31:0] total;
    logic [31:0] elapsed;
    logic [31:0] pct;
    total = shd_length * 32'd60;
    if (left == 0) return 7'd100;
    if (total == 0) return 7'd0;
    elapsed = (left >= total) ? 32'd0 : total - left;
    pct = (elapsed * 32'd100) / total;
    return (pct > 100) ? 7'd100 : pct[6:0];
  endfunction

  task automatic clear_session();
    shd_status   = ST_INACTIVE;
    shd_length   = '0;
    shd_deadline = '0;
    shd_frozen   = '0;
    shd_done     = 1'b0;
    shd_done_at  = '0;
  endtask

  task automatic close_session(logic [62:0] now);
    shd_status   = ST_INACTIVE;
    shd_deadline = '0;
    shd_frozen   = '0;
    shd_done     = 1'b1;
    shd_done_at  = now;
  endtask

  // Apply one command to the shadow state and queue the report it yields.
  task automatic advance_session(kind_e kind, logic [15:0] mins, logic [62:0] now);
    logic        ok;
    logic [63:0] secs;
    logic [31:0] left;
    logic [31:0] added;
    logic [31:0] cap;
    logic        good;
    report_t     rep;
    ok = 1'b0;
    if (kind == KIND_CANCEL) begin
      if (shd_status != ST_INACTIVE) begin
        clear_session();
        ok = 1'b1;
      end
    end else if (now != 0 && kind != KIND_BAD) begin
      case (kind)
        KIND_START: begin
          secs = mins * 64'd60;
          if (mins >= shd_min && mins <= shd_max && {1'b0, now} <= {1'b0, TIME_TOP} - secs)
          begin
            clear_session();
            shd_status   = ST_RUNNING;
            shd_length   = mins;
            shd_deadline = {1'b0, now} + secs;
            ok = 1'b1;
          end
        end
        KIND_PAUSE: begin
          if (shd_status == ST_RUNNING) begin
            left = secs_to_go(now);
            if (left == 0) begin
              close_session(now);
            end else begin
              shd_status   = ST_PAUSED;
              shd_frozen   = left;
              shd_deadline = '0;
            end
            ok = 1'b1;
          end
        end
        KIND_RESUME: begin
          if (shd_status == ST_PAUSED && shd_frozen != 0 &&
              {1'b0, now} <= {1'b0, TIME_TOP} - shd_frozen) begin
            shd_status   = ST_RUNNING;
            shd_deadline = {1'b0, now} + shd_frozen;
            shd_frozen   = '0;
            ok = 1'b1;
          end
        end
        KIND_ADD: begin
          if (shd_status != ST_INACTIVE && mins != 0) begin
            added = mins * 32'd60;
            left  = secs_to_go(now);
            cap   = shd_max * 32'd60;
            good  = left < cap && added <= cap - left &&
                    (32'(shd_length) + mins) <= 32'(shd_max);
            if (good && shd_status == ST_RUNNING &&
                shd_deadline > {1'b0, TIME_TOP} - added) good = 1'b0;
            if (good) begin
              shd_length = shd_length + mins;
              if (shd_status == ST_PAUSED) shd_frozen = left + added;
              else shd_deadline = shd_deadline + added;
              ok = 1'b1;
            end
          end
        end
        KIND_END: begin
          if (shd_status != ST_INACTIVE) begin
            close_session(now);
            ok = 1'b1;
          end
        end
        default: begin
          // Snapshot ends an expired running session before it reports.
          if (shd_status == ST_RUNNING && secs_to_go(now) == 0) close_session(now);
          ok = 1'b1;
        end
      endcase
    end
    left           = secs_to_go(now);
    rep.accepted   = ok;
    rep.status     = shd_status;
    rep.length_min = shd_length;
    rep.remaining  = left;
    rep.pct        = pct_elapsed(left);
    rep.done       = shd_done;
    rep.done_at    = shd_done_at;
    pending_reports.push_back(rep);
  endtask

  // Watch accepted commands and register writes, and predict their reports.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_MIN_MINUTES) shd_min = cfg_data_i;
      else if (cfg_index_i == REG_MAX_MINUTES) shd_max = cfg_data_i;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      advance_session(kind_e'(s_axis_tdata[2:0]), s_axis_tdata[18:3], s_axis_tdata[81:19]);
  end

  // Compare each report transaction with the oldest prediction.
  always @(posedge clk_i) begin
    report_t want;
    report_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted   = m_axis_tdata[0];
      got.status     = sess_e'(m_axis_tdata[2:1]);
      got.length_min = m_axis_tdata[18:3];
      got.remaining  = m_axis_tdata[50:19];
      got.pct        = m_axis_tdata[57:51];
      got.done       = m_axis_tdata[58];
      got.done_at    = m_axis_tdata[121:59];
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.accepted !== want.accepted) begin
          $display("%0t: accepted exp %0d got %0d", $time, want.accepted, got.accepted);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.length_min !== want.length_min) begin
          $display("%0t: length exp %0d got %0d", $time, want.length_min, got.length_min);
          error_count++;
        end
        if (got.remaining !== want.remaining) begin
          $display("%0t: remaining exp %0d got %0d", $time, want.remaining, got.remaining);
          error_count++;
        end
        if (got.pct !== want.pct) begin
          $display("%0t: progress exp %0d got %0d", $time, want.pct, got.pct);
          error_count++;
        end
        if (got.done !== want.done) begin
          $display("%0t: done exp %0d got %0d", $time, want.done, got.done);
          error_count++;
        end
        if (got.done_at !== want.done_at) begin
          $display("%0t: done time exp %0d got %0d", $time, want.done_at, got.done_at);
          error_count++;
        end
      end
    end
  end

  // Offer one command and hold it until the block takes it.
  task automatic send_command(kind_e kind, logic [15:0] mins, logic [62:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, now, mins, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every report is in, plus the block's command latency.
  task automatic drain_reports();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_register(logic [7:0] index, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(logic [15:0] lo, logic [15:0] hi);
    drain_reports();
    write_register(REG_MIN_MINUTES, lo);
    write_register(REG_MAX_MINUTES, hi);
  endtask

  // Edge cases of every command at the reset limits.
  task automatic test_directed();
    send_command(KIND_BAD, 16'd5, 63'd5);
    send_command(KIND_START, 16'd2, 63'd0);
    send_command(KIND_START, 16'd0, 63'd1000);
    send_command(KIND_START, 16'hFFFF, 63'd1000);
    send_command(KIND_START, 16'd2, 63'd1000);
    send_command(KIND_SNAP, 16'd0, 63'd1030);
    send_command(KIND_PAUSE, 16'd0, 63'd1060);
    send_command(KIND_PAUSE, 16'd0, 63'd1070);
    send_command(KIND_ADD, 16'd0, 63'd1080);
    send_command(KIND_ADD, 16'd1, 63'd1100);
    send_command(KIND_ADD, 16'd200, 63'd1110);
    send_command(KIND_RESUME, 16'd0, 63'd1200);
    send_command(KIND_ADD, 16'd1, 63'd1250);
    send_command(KIND_END, 16'd0, 63'd1300);
    send_command(KIND_SNAP, 16'd0, 63'd1310);
    send_command(KIND_CANCEL, 16'd0, 63'd0);
    send_command(KIND_START, 16'd3, 63'd2000);
    send_command(KIND_SNAP, 16'd0, 63'd2500);
    send_command(KIND_START, 16'd1, 63'd3000);
    send_command(KIND_PAUSE, 16'd0, 63'd3100);
    send_command(KIND_START, 16'd120, TIME_TOP - 63'd7199);
    send_command(KIND_START, 16'd60, TIME_TOP - 63'd7200);
    send_command(KIND_ADD, 16'd60, TIME_TOP - 63'd7200);
    send_command(KIND_SNAP, 16'd0, 63'd0);
    send_command(KIND_CANCEL, 16'hFFFF, TIME_TOP);
    stop_sending();
  endtask

  // Random command mixed around a slowly advancing clock.
  task automatic send_random_command();
    int          pick;
    kind_e       kind;
    logic [15:0] mins;
    logic [62:0] now;
    pick = $urandom_range(99);
    if (pick < 20) kind = KIND_START;
    else if (pick < 32) kind = KIND_PAUSE;
    else if (pick < 44) kind = KIND_RESUME;
    else if (pick < 60) kind = KIND_ADD;
    else if (pick < 68) kind = KIND_END;
    else if (pick < 75) kind = KIND_CANCEL;
    else if (pick < 97) kind = KIND_SNAP;
    else kind = KIND_BAD;
    pick = $urandom_range(99);
    if (pick < 15) mins = 16'($urandom);
    else if (kind == KIND_START)
      mins = 16'(shd_min + $urandom_range(0, (shd_max > shd_min + 8) ? 8 : shd_max - shd_min));
    else mins = 16'($urandom_range(0, 6));
    clock_secs = clock_secs + $urandom_range(0, ($urandom_range(9) == 0) ? 20000 : 400);
    pick = $urandom_range(99);
    if (pick < 2) now = '0;
    else if (pick < 5) now = 63'({$urandom, $urandom});
    else if (pick < 7) now = TIME_TOP - $urandom_range(0, 9000);
    else now = clock_secs;
    send_command(kind, mins, now);
  endtask

  task automatic test_random(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_random_command();
    stop_sending();
  endtask

  // Hold the output off long enough that the block stalls its input.
  task automatic test_backpressure();
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 400;
    repeat (20) send_random_command();
    stop_sending();
    drain_reports();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    error_count    = 0;
    cycle_count    = 0;
    rx_hold_cycles = 0;
    tx_idle_pct    = 37;
    rx_idle_pct    = 76;
    clock_secs     = 63'd10000;
    shd_min        = MIN_MINUTES_RST;
    shd_max        = MAX_MINUTES_RST;
    clear_session();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(130, 37, 76);
    set_limits(16'd0, 16'hFFFF);
    test_random(130, 76, 37);
    set_limits(16'd1, 16'd1);
    test_random(130, 0, 0);
    test_backpressure();
    set_limits(16'hFFFF, 16'hFFFF);
    test_random(100, 37, 76);
    set_limits(16'd30, 16'd60);
    test_random(130, 76, 37);
    set_limits(MIN_MINUTES_RST, MAX_MINUTES_RST);
    test_random(130, 0, 0);

    drain_reports();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
